// File: design/selective_repeat_sender_assert.svh
// Assertion macros for the selective-repeat sender.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef SELECTIVE_REPEAT_SENDER_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/srs_pkg.sv
// Shared types and constants for the selective-repeat sender.
// Used by srs_ctrl, srs_dp and selective_repeat_sender; depends on nothing.
`timescale 1ns / 1ps

package srs_pkg;

    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned TOTAL_W   = 9;
    localparam int unsigned SEQ_W     = 4;
    localparam int unsigned PAYLOAD_W = 9;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2;
    localparam logic [TOTAL_W-1:0]   TOTAL_RST   = 9'd5;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept_tick;
        logic accept_ack;
        logic slide;
        logic scan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic can_slide;
        logic mask_empty;
        logic out_free;
    } t_dp_status;

endpackage

// File: design/srs_ctrl.sv
// Controller state machine of the selective-repeat sender.
// Depends on srs_pkg; drives the command struct of srs_dp.
`timescale 1ns / 1ps

module srs_ctrl import srs_pkg::*; #(
    parameter int WINDOW = 3,
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd,
    output logic [SLOT_W-1:0] o_scan_k,
    output logic              o_in_stall,
    output logic              o_cfg_ready
);

    localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(WINDOW - 1);

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_k;
    logic [SLOT_W-1:0] n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Next state and scan slot counter.
    always_comb begin
        n_state = r_state;
        n_k     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_operation == OP_ACK) ? ST_SLIDE : ST_SCAN;
                end
            end
            ST_SLIDE: begin
                if (!i_status.can_slide) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_k == LAST_K) begin
                    n_state = ST_EMIT;
                end else begin
                    n_k = r_k + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                if (i_status.mask_empty) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall       = 1'b0;
                o_cfg_ready      = 1'b1;
                o_cmd.accept_tick = i_in_valid && (i_operation == OP_TICK);
                o_cmd.accept_ack  = i_in_valid && (i_operation == OP_ACK);
            end
            ST_SLIDE: o_cmd.slide = i_status.can_slide;
            ST_SCAN:  o_cmd.scan  = 1'b1;
            ST_EMIT:  o_cmd.emit  = !i_status.mask_empty && i_status.out_free;
            default:  o_cmd       = '0;
        endcase
    end

    assign o_scan_k = r_k;

endmodule

// File: design/srs_dp.sv
// Datapath of the selective-repeat sender: configuration, tick counter, window slots
// and the output register. Depends on srs_pkg; controlled by srs_ctrl.
`timescale 1ns / 1ps

module srs_dp import srs_pkg::*; #(
    parameter int WINDOW      = 3,
    parameter int MAX_PACKETS = 256,
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIMEOUT_W-1:0] i_cfg_data,
    input  logic [SEQ_W-1:0]     i_ack_number,
    input  t_dp_cmd              i_cmd,
    input  logic [SLOT_W-1:0]    i_scan_k,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SEQ_W-1:0]     o_seq_number,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic                 o_last,
    output logic                 o_all_done
);

    localparam int BASE_W = $clog2(MAX_PACKETS + 1);
    localparam int CMP_W  = ((BASE_W > TOTAL_W) ? BASE_W : TOTAL_W) + 1;
    localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_PACKETS);
    localparam logic [SEQ_W:0]   MODN     = (SEQ_W + 1)'(WINDOW + 1);
    localparam logic [SEQ_W-1:0] MOD_LAST = SEQ_W'(WINDOW);

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [TOTAL_W-1:0]   r_total;
    logic [TICK_W-1:0]    r_tick;
    logic [BASE_W-1:0]    r_base;
    logic [SEQ_W-1:0]     r_base_mod;
    logic                 r_sent  [WINDOW];
    logic                 r_acked [WINDOW];
    logic [TICK_W-1:0]    r_stamp [WINDOW];
    logic [WINDOW-1:0]    r_mask;

    logic                 r_out_valid;
    logic [SEQ_W-1:0]     r_out_seq;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic                 r_out_last;
    logic                 r_out_done;

    logic [CMP_W-1:0]     w_total_eff;
    logic [CMP_W-1:0]     w_base_ext;
    logic [WINDOW-1:0]    w_in_range;
    logic [SEQ_W-1:0]     w_seq [WINDOW];
    logic [WINDOW-1:0]    w_ack_hit;
    logic [SLOT_W-1:0]    w_ack_sel;
    logic [TICK_W-1:0]    w_age;
    logic                 w_due;
    logic [SLOT_W-1:0]    w_emit_sel;
    logic                 w_emit_last;
    logic [CMP_W-1:0]     w_payload_sum;
    logic                 w_done;
    logic                 w_cfg_we;

    assign w_cfg_we    = i_cfg_valid && i_cfg_ready;
    assign w_total_eff = (CMP_W'(r_total) > MAX_CMP) ? MAX_CMP : CMP_W'(r_total);
    assign w_base_ext  = CMP_W'(r_base);
    assign w_done      = (w_base_ext >= w_total_eff);

    // Per-slot range check and sequence number; slot j holds packet base + j.
    always_comb begin
        logic [SEQ_W:0] v_sum;
        v_sum = '0;
        for (int j = 0; j < WINDOW; j++) begin
            w_in_range[j] = (w_base_ext + CMP_W'(j)) < w_total_eff;
            v_sum         = (SEQ_W + 1)'(r_base_mod) + (SEQ_W + 1)'(j);
            w_seq[j]      = (v_sum >= MODN) ? SEQ_W'(v_sum - MODN) : SEQ_W'(v_sum);
            w_ack_hit[j]  = w_in_range[j] && !r_acked[j] && (w_seq[j] == i_ack_number);
        end
    end

    // The lowest matching slot takes the ack.
    always_comb begin
        w_ack_sel = '0;
        for (int j = WINDOW - 1; j >= 0; j--) begin
            if (w_ack_hit[j]) begin
                w_ack_sel = SLOT_W'(j);
            end
        end
    end

    assign w_age = r_tick - r_stamp[i_scan_k];
    assign w_due = w_in_range[i_scan_k] && !r_acked[i_scan_k] &&
                   (!r_sent[i_scan_k] || (w_age >= TICK_W'(r_timeout)));

    // Sends go out in window order: lowest pending slot first.
    always_comb begin
        w_emit_sel = '0;
        for (int j = WINDOW - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                w_emit_sel = SLOT_W'(j);
            end
        end
    end

    assign w_emit_last   = ((r_mask & ~(WINDOW'(1) << w_emit_sel)) == '0);
    assign w_payload_sum = w_base_ext + CMP_W'(w_emit_sel) + CMP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_total   <= TOTAL_RST;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_TOTAL:   r_total   <= i_cfg_data[TOTAL_W-1:0];
                default:     r_timeout <= r_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_base     <= '0;
            r_base_mod <= '0;
        end else begin
            if (i_cmd.accept_tick) begin
                r_tick <= r_tick + TICK_W'(1);
            end
            if (i_cmd.slide) begin
                r_base     <= r_base + BASE_W'(1);
                r_base_mod <= (r_base_mod == MOD_LAST) ? '0 : r_base_mod + SEQ_W'(1);
            end
        end
    end

    // Slot flags. A slide drops the acked packet at the bottom; the packet that enters
    // at the top has never been inside the window, so it starts clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WINDOW; j++) begin
                r_sent[j]  <= 1'b0;
                r_acked[j] <= 1'b0;
            end
        end else if (i_cmd.slide) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
                r_sent[j]  <= r_sent[j + 1];
                r_acked[j] <= r_acked[j + 1];
            end
            r_sent[WINDOW - 1]  <= 1'b0;
            r_acked[WINDOW - 1] <= 1'b0;
        end else begin
            if (i_cmd.accept_ack && (w_ack_hit != '0)) begin
                r_acked[w_ack_sel] <= 1'b1;
            end
            if (i_cmd.scan && w_due) begin
                r_sent[i_scan_k] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slide) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
                r_stamp[j] <= r_stamp[j + 1];
            end
        end else if (i_cmd.scan && w_due) begin
            r_stamp[i_scan_k] <= r_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cmd.accept_tick || i_cmd.accept_ack) begin
            r_mask <= '0;
        end else if (i_cmd.scan && w_due) begin
            r_mask[i_scan_k] <= 1'b1;
        end else if (i_cmd.emit) begin
            r_mask[w_emit_sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_seq     <= w_seq[w_emit_sel];
            r_out_payload <= w_payload_sum[PAYLOAD_W-1:0];
            r_out_last    <= w_emit_last;
            r_out_done    <= w_done;
        end
    end

    assign o_status.can_slide  = (w_base_ext < w_total_eff) && r_acked[0];
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_seq_number = r_out_seq;
    assign o_payload    = r_out_payload;
    assign o_last       = r_out_last;
    assign o_all_done   = r_out_done;

endmodule

// File: design/selective_repeat_sender.sv
// Selective-repeat ARQ sender window, top level.
// Input channel: i_in_valid / o_in_stall with i_operation (tick or ack) and i_ack_number.
// Output channel: o_out_valid / i_out_stall, one item per packet send, in window order,
// with o_last set on the final send caused by one input item.
// Configuration: i_cfg_valid / o_cfg_ready, index 0 = timeout in ticks, 1 = total packets.
// An input item passes an accept step, a scan of the WINDOW slots (one window slot per cycle through
// the shared age compare), one send per pending slot and a closing step. An ack first slides
// the base over every acked packet at the bottom, then goes on to the scan.
// A new item is taken once all sends of the previous one sit in or have left the output
// register, so it may be accepted while the last result still waits.
// A stall on the output holds the output register and pauses the send sequence.
// Reset (synchronous, active low) clears the window, the tick count and the output, and
// restores timeout 2 and total 5. There is no clearing pass.
`timescale 1ns / 1ps

module selective_repeat_sender import srs_pkg::*; #(
    parameter int WINDOW      = 3,
    parameter int MAX_PACKETS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [SEQ_W-1:0]     i_ack_number,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SEQ_W-1:0]     o_seq_number,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic                 o_last,
    output logic                 o_all_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIMEOUT_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [SLOT_W-1:0] w_scan_k;

    srs_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_scan_k    (w_scan_k),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    srs_dp #(
        .WINDOW      (WINDOW),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_ack_number (i_ack_number),
        .i_cmd        (w_cmd),
        .i_scan_k     (w_scan_k),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_seq_number (o_seq_number),
        .o_payload    (o_payload),
        .o_last       (o_last),
        .o_all_done   (o_all_done)
    );

`include "selective_repeat_sender_assert.svh"

    // A finished message has an empty window, so no send can carry the done flag.
    `SRS_ASSERT_SAME(a_no_send_when_done, o_out_valid, !o_all_done, "send after all done")

    `SRS_ASSERT_SAME(a_seq_in_range, o_out_valid, o_seq_number <= SEQ_W'(WINDOW),
        "sequence number beyond window modulus")

    // While taking new items, no send of the previous item may still be pending.
    `SRS_ASSERT_SAME(a_idle_mask_empty, !o_in_stall, w_status.mask_empty,
        "input accepted with sends pending")

    // An emit always fills the output register on the next edge.
    `SRS_ASSERT_NEXT(a_emit_fills_out, w_cmd.emit, o_out_valid, "emit lost")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the selective-repeat sender window.
// Depends on srs_pkg and selective_repeat_sender; a send tracker predicts every packet send.
`timescale 1ns / 1ps

module tb_top import srs_pkg::*; ();

    localparam int          WINDOW     = 3;
    localparam int          MAX_PKT    = 256;
    localparam int          RAND_ITEMS = 160;
    localparam int          SETTLE     = 40;
    localparam int unsigned LIMIT      = 500000;

    typedef struct packed {
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
        logic                 all_done;
    } t_send_rec;

    // Tracks the sender window and keeps the packet sends still owed by the block.
    class t_send_tracker;
        bit [TIMEOUT_W-1:0] timeout;
        bit [TOTAL_W-1:0]   total_cfg;
        bit [TICK_W-1:0]    ticks;
        bit [TICK_W-1:0]    stamp [MAX_PKT];
        bit                 sent  [MAX_PKT];
        bit                 acked [MAX_PKT];
        int unsigned        base;
        t_send_rec          pending [$];
        int                 errors;

        function new();
            timeout   = TIMEOUT_RST;
            total_cfg = TOTAL_RST;
            ticks     = '0;
            base      = 0;
            errors    = 0;
            foreach (sent[i]) begin
                sent[i]  = 1'b0;
                acked[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMEOUT_W-1:0] data);
            if (idx == CFG_TIMEOUT)
                timeout = data;
            else
                total_cfg = data[TOTAL_W-1:0];
        endfunction

        function int unsigned eff_total();
            return (total_cfg > MAX_PKT) ? MAX_PKT : total_cfg;
        endfunction

        // Sequence number of a random unacked packet in the window, or -1 if none.
        function int open_seq();
            int cand [$];
            for (int unsigned i = base; i < base + WINDOW && i < eff_total(); i++)
                if (!acked[i])
                    cand.push_back(int'(i % (WINDOW + 1)));
            if (cand.size() == 0)
                return -1;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        function void note_input(logic op, logic [SEQ_W-1:0] ackn);
            int unsigned     lim;
            int              n;
            bit              done;
            bit              due;
            bit [TICK_W-1:0] age;
            t_send_rec       s;
            lim = eff_total();
            n   = 0;
            if (op == OP_TICK) begin
                ticks = ticks + TICK_W'(1);
            end else begin
                for (int unsigned i = base; i < base + WINDOW && i < lim; i++) begin
                    if ((i % (WINDOW + 1)) == ackn && !acked[i]) begin
                        acked[i] = 1'b1;
                        while (base < lim && base < MAX_PKT && acked[base])
                            base++;
                        break;
                    end
                end
            end
            done = (base >= lim);
            for (int unsigned i = base; i < base + WINDOW && i < lim; i++) begin
                if (!acked[i]) begin
                    age = ticks - stamp[i];
                    due = !sent[i] || (age >= timeout);
                    if (due) begin
                        sent[i]    = 1'b1;
                        stamp[i]   = ticks;
                        s.seq      = SEQ_W'(i % (WINDOW + 1));
                        s.payload  = PAYLOAD_W'(i + 1);
                        s.last     = 1'b0;
                        s.all_done = done;
                        pending.push_back(s);
                        n++;
                    end
                end
            end
            // The final send of this item carries the last marker.
            if (n > 0) begin
                s = pending.pop_back();
                s.last = 1'b1;
                pending.push_back(s);
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [SEQ_W-1:0] seq, logic [PAYLOAD_W-1:0] payload,
                          logic last, logic all_done);
            t_send_rec want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected send seq %0d payload %0d", seq, payload));
                return;
            end
            want = pending.pop_front();
            if (seq !== want.seq)
                report($sformatf("seq_number %0d, want %0d", seq, want.seq));
            if (payload !== want.payload)
                report($sformatf("payload %0d, want %0d", payload, want.payload));
            if (last !== want.last)
                report($sformatf("last %0b, want %0b (payload %0d)", last, want.last,
                                 want.payload));
            if (all_done !== want.all_done)
                report($sformatf("all_done %0b, want %0b (payload %0d)", all_done,
                                 want.all_done, want.payload));
        endtask
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic                 i_operation  = OP_TICK;
    logic [SEQ_W-1:0]     i_ack_number = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [SEQ_W-1:0]     o_seq_number;
    logic [PAYLOAD_W-1:0] o_payload;
    logic                 o_last;
    logic                 o_all_done;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_TIMEOUT;
    logic [TIMEOUT_W-1:0] i_cfg_data   = '0;

    t_send_tracker sb;
    bit            steady      = 1'b0;
    int unsigned   cycle_count = 0;

    selective_repeat_sender #(
        .WINDOW      (WINDOW),
        .MAX_PACKETS (MAX_PKT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_ack_number (i_ack_number),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_seq_number (o_seq_number),
        .o_payload    (o_payload),
        .o_last       (o_last),
        .o_all_done   (o_all_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_seq_number, o_payload, o_last, o_all_done);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [SEQ_W-1:0] ackn);
        if (!steady) begin
            while ($urandom_range(99) < 32) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_ack_number <= ackn;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_input(op, ackn);
    endtask

    task automatic send_ack(input int seq);
        send_item(OP_ACK, SEQ_W'(seq));
    endtask

    // Waits until every owed send has arrived, then lets the block finish items
    // that produce nothing.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= TIMEOUT_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, TIMEOUT_W'(data));
        @(posedge i_clk);
    endtask

    initial begin
        int          n_rand;
        int          n_phase;
        int          phase;
        int          seq;
        int unsigned pick;
        int unsigned new_timeout;
        int unsigned new_total;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first sends, a timed resend, ignored and duplicate acks,
        // out-of-order acks and a base that slides to the end of the message.
        send_item(OP_TICK, '0);
        send_item(OP_TICK, 4'hF);
        send_item(OP_TICK, '0);
        send_ack(15);
        send_ack(1);
        send_ack(0);
        send_ack(2);
        send_ack(3);
        send_ack(0);
        send_ack(0);
        send_item(OP_TICK, '0);
        wait_drained();

        // Empty message, then a total lowered below the base.
        write_reg(CFG_TIMEOUT, 0);
        write_reg(CFG_TOTAL, 0);
        send_item(OP_TICK, '0);
        send_ack(0);
        wait_drained();
        write_reg(CFG_TOTAL, 3);
        send_item(OP_TICK, '0);
        wait_drained();

        // Oversized total saturates; a zero timeout resends on every item.
        write_reg(CFG_TOTAL, 511);
        send_item(OP_TICK, '0);
        send_ack(2);
        send_item(OP_TICK, '0);
        wait_drained();

        // Largest timeout: nothing is ever resent.
        write_reg(CFG_TIMEOUT, 65535);
        write_reg(CFG_TOTAL, 9);
        send_ack(1);
        send_item(OP_TICK, '0);
        send_ack(9);
        wait_drained();

        n_rand = 0;
        phase  = 0;
        while (n_rand < RAND_ITEMS) begin
            if (phase == 0) begin
                new_timeout = 1;
                new_total   = MAX_PKT;
            end else begin
                case ($urandom_range(7))
                    0:       new_timeout = 0;
                    1:       new_timeout = 65535;
                    2:       new_timeout = $urandom_range(1, 65535);
                    default: new_timeout = $urandom_range(1, 6);
                endcase
                case ($urandom_range(7))
                    0:       new_total = (sb.base > 0) ? $urandom_range(0, sb.base - 1) : 0;
                    1:       new_total = 511;
                    2:       new_total = $urandom_range(257, 511);
                    default: new_total = sb.base + $urandom_range(1, 20);
                endcase
                if (new_total > 511)
                    new_total = 511;
            end
            write_reg(CFG_TIMEOUT, new_timeout);
            write_reg(CFG_TOTAL, new_total);
            n_phase = $urandom_range(15, 35);
            for (int k = 0; k < n_phase && n_rand < RAND_ITEMS; k++) begin
                steady = (n_rand >= 40 && n_rand < 100);
                if (n_rand == 120)
                    wait_drained();
                pick = $urandom_range(99);
                seq  = sb.open_seq();
                if (pick < 30)
                    send_item(OP_TICK, SEQ_W'($urandom_range(15)));
                else if (pick < 80 && seq >= 0)
                    send_ack(seq);
                else
                    send_ack($urandom_range(15));
                n_rand++;
            end
            steady = 1'b0;
            wait_drained();
            phase++;
        end

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
